FILE: rtl/core/sfip_pkg.sv
// ----------------------------------------------------------------------------
// sfip_pkg
// Shared types and constants for the status frame integer parser.
// ----------------------------------------------------------------------------
package sfip_pkg;

    // Character codes used by the header check and the byte classifier.
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Position of the closing 'D' within the five-byte header.
    localparam logic [2:0] HDR_LAST_POS = 3'd4;

    localparam logic [6:0] EXPECTED_TOKENS_RESET = 7'd82;
    localparam int         VALUE_BITS_DEFAULT    = 32;
    localparam int         QUEUE_DEPTH_DEFAULT   = 4;

    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_SPACE = 2'd1,
        CLS_MINUS = 2'd2,
        CLS_OTHER = 2'd3
    } byte_class_t;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
        logic        is_v;
        logic        is_d;
    } byte_info_t;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } phase_t;

    typedef enum logic [1:0] {
        NUM_NONE   = 2'd0,
        NUM_SIGN   = 2'd1,
        NUM_DIGITS = 2'd2
    } num_state_t;

    typedef enum logic [1:0] {
        KIND_TOKEN     = 2'd0,
        KIND_FRAME_END = 2'd1,
        KIND_HDR_ERR   = 2'd2
    } result_kind_t;

endpackage

FILE: rtl/core/sfip_front.sv
// ----------------------------------------------------------------------------
// sfip_front
// Accepts stream bytes and classifies them before they enter the queue.
// ----------------------------------------------------------------------------
module sfip_front
    import sfip_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] stream_byte,
    input  logic       queue_full,
    output logic       push,
    output byte_info_t push_info
);

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_info.digit = stream_byte[3:0];
        push_info.is_v  = (stream_byte == CH_V);
        push_info.is_d  = (stream_byte == CH_D);
        unique case (stream_byte) inside
            [CH_0:CH_9]:                     push_info.cls = CLS_DIGIT;
            CH_SPACE, CH_TAB, CH_CR, CH_LF:  push_info.cls = CLS_SPACE;
            CH_MINUS:                        push_info.cls = CLS_MINUS;
            default:                         push_info.cls = CLS_OTHER;
        endcase
    end

endmodule

FILE: rtl/core/sfip_queue.sv
// ----------------------------------------------------------------------------
// sfip_queue
// Small register FIFO that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
module sfip_queue
    import sfip_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  byte_info_t push_info,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output byte_info_t head_info
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    byte_info_t          entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_info  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_info;
        end
    end

endmodule

FILE: rtl/core/sfip_back.sv
// ----------------------------------------------------------------------------
// sfip_back
// Header check, body integer parsing and the registered result stage.
// ----------------------------------------------------------------------------
module sfip_back
    import sfip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [6:0]  expected_tokens,
    input  logic        head_valid,
    input  byte_info_t  head_info,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] token_value,
    output logic [6:0]  token_index,
    output logic        last_of_frame,
    output logic [6:0]  token_count,
    output logic        count_matches
);

    phase_t                phase_reg, phase_next;
    logic [2:0]            hdr_pos_reg, hdr_pos_next;
    logic                  hdr_bad_reg, hdr_bad_next;
    logic [9:0]            hdr_len_reg, hdr_len_next;
    logic [9:0]            body_rem_reg, body_rem_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    num_state_t            nopen_reg, nopen_next;
    logic [6:0]            count_reg, count_next;
    logic                  stopped_reg, stopped_next;

    logic                  out_valid_reg, out_valid_next;
    result_kind_t          kind_reg, kind_next;
    logic [31:0]           value_reg, value_next;
    logic [6:0]            index_reg, index_next;
    logic                  last_reg, last_next;
    logic [6:0]            cnt_out_reg, cnt_out_next;
    logic                  match_reg, match_next;

    logic                  advance;
    logic                  hdr_bad_now;
    logic [9:0]            hdr_len_now;
    logic [9:0]            rem_dec;
    logic                  last_byte;
    logic                  hdr_done;

    function automatic logic [31:0] finish_value(input logic [VALUE_BITS-1:0] a,
                                                 input logic                  n);
        logic signed [VALUE_BITS-1:0] v;
        v = n ? ({VALUE_BITS{1'b0}} - a) : a;
        return 32'(v);
    endfunction

    function automatic logic [VALUE_BITS-1:0] times_ten_plus(
        input logic [VALUE_BITS-1:0] a,
        input logic [3:0]            d);
        return (a << 3) + (a << 1) + VALUE_BITS'(d);
    endfunction

    // The result stage takes a new result whenever it is empty or being drained.
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = head_valid && advance;

    // Header bookkeeping for the byte at the queue head.
    always_comb
    begin
        if (hdr_pos_reg == '0)
        begin
            hdr_bad_now = !head_info.is_v;
            hdr_len_now = '0;
        end
        else if (hdr_pos_reg < HDR_LAST_POS)
        begin
            hdr_bad_now = hdr_bad_reg || (head_info.cls != CLS_DIGIT);
            hdr_len_now = (head_info.cls == CLS_DIGIT)
                        ? 10'(hdr_len_reg * 4'd10 + {6'd0, head_info.digit})
                        : hdr_len_reg;
        end
        else
        begin
            hdr_bad_now = hdr_bad_reg || !head_info.is_d;
            hdr_len_now = hdr_len_reg;
        end
    end

    assign hdr_done  = (hdr_pos_reg == HDR_LAST_POS);
    assign rem_dec   = body_rem_reg - 1'b1;
    assign last_byte = (rem_dec == '0);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_done && !hdr_bad_now && hdr_len_now != '0)
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (last_byte)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    // Datapath and result generation.
    always_comb
    begin
        logic             emit;
        logic             stop;
        logic [31:0]      val;
        logic [6:0]       idx;
        logic [6:0]       cnt_inc;

        hdr_pos_next   = hdr_pos_reg;
        hdr_bad_next   = hdr_bad_reg;
        hdr_len_next   = hdr_len_reg;
        body_rem_next  = body_rem_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        nopen_next     = nopen_reg;
        count_next     = count_reg;
        stopped_next   = stopped_reg;

        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        cnt_out_next   = cnt_out_reg;
        match_next     = match_reg;

        emit    = 1'b0;
        stop    = 1'b0;
        val     = '0;
        idx     = '0;
        cnt_inc = count_reg + 1'b1;

        if (advance)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_len_next = hdr_len_now;
                    if (!hdr_done)
                    begin
                        hdr_bad_next = hdr_bad_now;
                        hdr_pos_next = hdr_pos_reg + 1'b1;
                    end
                    else
                    begin
                        hdr_pos_next = '0;
                        hdr_bad_next = 1'b0;
                        if (hdr_bad_now)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_HDR_ERR;
                            value_next     = '0;
                            index_next     = '0;
                            last_next      = 1'b1;
                            cnt_out_next   = '0;
                            match_next     = 1'b0;
                        end
                        else
                        begin
                            count_next    = '0;
                            stopped_next  = 1'b0;
                            nopen_next    = NUM_NONE;
                            acc_next      = '0;
                            neg_next      = 1'b0;
                            body_rem_next = hdr_len_now;
                            if (hdr_len_now == '0)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_FRAME_END;
                                value_next     = '0;
                                index_next     = '0;
                                last_next      = 1'b1;
                                cnt_out_next   = '0;
                                match_next     = (expected_tokens == '0);
                            end
                        end
                    end
                end

                PH_BODY:
                begin
                    body_rem_next = rem_dec;
                    stop = stopped_reg || (count_reg >= expected_tokens);

                    if (!stop)
                    begin
                        // A byte that closes a number is then judged afresh, unless the expected count is reached.
                        logic fresh;
                        fresh = 1'b0;
                        case (nopen_reg)
                            NUM_DIGITS:
                            begin
                                if (head_info.cls == CLS_DIGIT)
                                begin
                                    acc_next = times_ten_plus(acc_reg, head_info.digit);
                                end
                                else
                                begin
                                    emit       = 1'b1;
                                    val        = finish_value(acc_reg, neg_reg);
                                    idx        = count_reg;
                                    count_next = cnt_inc;
                                    if (cnt_inc >= expected_tokens)
                                    begin
                                        stop = 1'b1;
                                    end
                                    else
                                    begin
                                        fresh = 1'b1;
                                    end
                                end
                            end
                            NUM_SIGN:
                            begin
                                if (head_info.cls == CLS_DIGIT)
                                begin
                                    acc_next   = VALUE_BITS'(head_info.digit);
                                    nopen_next = NUM_DIGITS;
                                end
                                else
                                begin
                                    stop = 1'b1;
                                end
                            end
                            default: fresh = 1'b1;
                        endcase

                        if (fresh)
                        begin
                            acc_next   = '0;
                            neg_next   = 1'b0;
                            nopen_next = NUM_NONE;
                            case (head_info.cls)
                                CLS_SPACE: ;
                                CLS_MINUS:
                                begin
                                    neg_next   = 1'b1;
                                    nopen_next = NUM_SIGN;
                                end
                                CLS_DIGIT:
                                begin
                                    acc_next   = VALUE_BITS'(head_info.digit);
                                    nopen_next = NUM_DIGITS;
                                end
                                default: stop = 1'b1;
                            endcase
                        end
                    end
                    stopped_next = stop;

                    if (last_byte)
                    begin
                        // A number still open at the end of the body closes here.
                        if (!emit && !stop && nopen_next == NUM_DIGITS)
                        begin
                            emit       = 1'b1;
                            val        = finish_value(acc_next, neg_next);
                            idx        = count_reg;
                            count_next = cnt_inc;
                        end
                        out_valid_next = 1'b1;
                        kind_next      = emit ? KIND_TOKEN : KIND_FRAME_END;
                        value_next     = emit ? val : '0;
                        index_next     = emit ? idx : '0;
                        last_next      = 1'b1;
                        cnt_out_next   = count_next;
                        match_next     = (count_next == expected_tokens);
                        nopen_next     = NUM_NONE;
                        acc_next       = '0;
                        neg_next       = 1'b0;
                        stopped_next   = 1'b0;
                        count_next     = '0;
                    end
                    else if (emit)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_TOKEN;
                        value_next     = val;
                        index_next     = idx;
                        last_next      = 1'b0;
                        cnt_out_next   = count_next;
                        match_next     = 1'b0;
                    end
                end

                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_pos_reg   <= '0;
            hdr_bad_reg   <= 1'b0;
            hdr_len_reg   <= '0;
            body_rem_reg  <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            nopen_reg     <= NUM_NONE;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_pos_reg   <= hdr_pos_next;
            hdr_bad_reg   <= hdr_bad_next;
            hdr_len_reg   <= hdr_len_next;
            body_rem_reg  <= body_rem_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            nopen_reg     <= nopen_next;
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        index_reg   <= index_next;
        last_reg    <= last_next;
        cnt_out_reg <= cnt_out_next;
        match_reg   <= match_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign token_value   = value_reg;
    assign token_index   = index_reg;
    assign last_of_frame = last_reg;
    assign token_count   = cnt_out_reg;
    assign count_matches = match_reg;

endmodule

FILE: rtl/core/status_frame_integer_parser_top.sv
// ----------------------------------------------------------------------------
// status_frame_integer_parser_top
// Parses framed status bytes into signed integers and frame-end summaries.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, when the result side does not stall.
// A byte is first written into the queue, then parsed from the queue head into the
// result register, from which its result is offered.
// Reset (rst_n, asynchronous, active low) empties queue and result stage, restarts the
// header and sets expected_tokens to 82; bytes are taken right after reset.
// ----------------------------------------------------------------------------
//
// The front end classifies each byte (digit, separator, minus, other, and the
// 'V' and 'D' header marks) and pushes it into a short queue. The back end
// pops one entry per cycle whenever its result register is empty or being
// drained, so a stalled result side backs up into the queue first and only
// then into in_stall. Each stream byte makes at most one result transfer.
//
// The header is always five bytes long. A bad header produces a header error
// result on its fifth byte and the next byte starts a new header. Integers
// accumulate modulo 2^VALUE_BITS and are presented as 32-bit signed values.
// The expected_tokens register is written through cfg_we and cfg_wdata; it
// should only change while no bytes are in flight.
module status_frame_integer_parser_top
    import sfip_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,

    // Byte stream input.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,

    // Result output.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] token_value,
    output logic [6:0]  token_index,
    output logic        last_of_frame,
    output logic [6:0]  token_count,
    output logic        count_matches
);

    logic [6:0] expected_tokens_reg;

    logic       queue_full;
    logic       push;
    byte_info_t push_info;
    logic       pop;
    logic       head_valid;
    byte_info_t head_info;

    // The expected token count is a plain write-only register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_tokens_reg <= EXPECTED_TOKENS_RESET;
        end
        else if (cfg_we)
        begin
            expected_tokens_reg <= cfg_wdata;
        end
    end

    // Classifier: turns each accepted byte into a byte_info_t entry.
    sfip_front u_front
    (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_info   (push_info)
    );

    // Queue between classifier and parser.
    sfip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_info  (push_info),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_info  (head_info)
    );

    // Parser and result register.
    sfip_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .expected_tokens (expected_tokens_reg),
        .head_valid      (head_valid),
        .head_info       (head_info),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .token_value     (token_value),
        .token_index     (token_index),
        .last_of_frame   (last_of_frame),
        .token_count     (token_count),
        .count_matches   (count_matches)
    );

endmodule

FILE: rtl/core/sfip_checker.sv
// ----------------------------------------------------------------------------
// sfip_checker
// Port-level checks on the result stream of the status frame parser.
// ----------------------------------------------------------------------------
module sfip_checker
    import sfip_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [31:0] token_value,
    input logic [6:0]  token_index,
    input logic        last_of_frame,
    input logic [6:0]  token_count,
    input logic        count_matches
);

    // No result is offered at the edge after reset was seen applied.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered after reset");

    // A stalled result stays offered, with its kind, value and count unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
            && $stable(token_value) && $stable(token_count))
        else $error("stalled result changed");

    // A header error closes the frame and carries no integer or count.
    a_hdr_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_HDR_ERR |-> last_of_frame
            && token_count == 7'd0 && !count_matches && token_value == 32'd0)
        else $error("malformed header error result");

    // A result inside a frame is always an integer whose count follows its index.
    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_frame |-> result_kind == KIND_TOKEN
            && !count_matches && token_count == 7'(token_index + 7'd1))
        else $error("mid-frame result inconsistent");

endmodule

bind status_frame_integer_parser_top sfip_checker u_sfip_checker (.*);
